// ----- hdl/pva_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the pixel variance accumulator.
// Depends on nothing; every other file but pva_ram imports it.
package pva_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int FUNC_W  = 3;
	localparam int COORD_W = 8;
	localparam int CFG_W   = 9;
	localparam int IDX_W   = COORD_W + CFG_W + 1;
	localparam int SMP_W   = 16;
	localparam int SUM_W   = 32;
	localparam int SQ_W    = 48;
	localparam int CNT_W   = 16;
	localparam int VAR_W   = 32;
	localparam int NCH     = 3;
	localparam int NLANE   = 2 * NCH;
	localparam int DCNT_W  = $clog2(SQ_W);

	localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(256);

	localparam logic [FUNC_W-1:0] FUNC_ACC_RGB  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ACC_MONO = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET      = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_MUL,
		ST_SUB,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic [NCH-1:0][SUM_W-1:0] sum;
		logic [NCH-1:0][SQ_W-1:0]  sq;
		logic [CNT_W-1:0]          cnt;
	} store_word_t;

	typedef struct packed {
		logic [FUNC_W-1:0]         func;
		logic [COORD_W-1:0]        row;
		logic [COORD_W-1:0]        col;
		logic [NCH-1:0][SUM_W-1:0] value;
		logic [NCH-1:0][SQ_W-1:0]  square_sum;
		logic [CNT_W-1:0]          sample_total;
	} pva_item_t;

	typedef struct packed {
		logic [VAR_W-1:0] max_variance;
		logic [CNT_W-1:0] samples_now;
		logic             index_error;
	} pva_result_t;

	typedef struct packed {
		logic capture;
		logic ram_we;
		logic clr_we;
		logic div_load;
		logic div_step;
		logic mul;
		logic sub;
		logic out_exec;
		logic out_query;
	} pva_cmd_t;

	typedef struct packed {
		logic idx_err;
		logic op_query;
		logic op_write;
		logic n_zero;
		logic div_last;
		logic clr_last;
		logic out_free;
	} pva_sts_t;

endpackage

// ----- hdl/pva_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: valid/ready plus one operation word.
// Depends on pva_pkg.
interface pva_in_if;
	import pva_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [FUNC_W-1:0]       func;
	logic [COORD_W-1:0]      row;
	logic [COORD_W-1:0]      col;
	logic [SUM_W-1:0]        red_value;
	logic [SUM_W-1:0]        green_value;
	logic [SUM_W-1:0]        blue_value;
	logic [SQ_W-1:0]         red_square_sum;
	logic [SQ_W-1:0]         green_square_sum;
	logic [SQ_W-1:0]         blue_square_sum;
	logic [CNT_W-1:0]        sample_total;
	modport source (output valid, func, row, col, red_value, green_value, blue_value,
		red_square_sum, green_square_sum, blue_square_sum, sample_total, input ready);
	modport sink (input valid, func, row, col, red_value, green_value, blue_value,
		red_square_sum, green_square_sum, blue_square_sum, sample_total, output ready);
endinterface

// ----- hdl/pva_out_if.sv -----
`timescale 1ns / 1ps
// Output channel: valid/ready plus one result word.
// Depends on pva_pkg.
interface pva_out_if;
	import pva_pkg::*;
	logic               valid;
	logic               ready;
	logic [VAR_W-1:0]   max_variance;
	logic [CNT_W-1:0]   samples_now;
	logic               index_error;
	modport source (output valid, max_variance, samples_now, index_error, input ready);
	modport sink (input valid, max_variance, samples_now, index_error, output ready);
endinterface

// ----- hdl/pixel_variance_accumulator.sv -----
`timescale 1ns / 1ps
// Per-pixel running color statistics with variance query.
// Channels: in_ch carries one operation word (func, row, col, values, square
// sums, sample_total); out_ch returns one result word per accepted input word.
// cfg_we/cfg_wdata write image_width, which forms the index row*width+col.
// Accumulate, mono accumulate, set, clear and unknown codes issue the store
// read at acceptance, then write back (not for unknown codes) and result load.
// A query runs the divider lanes, which produce one quotient bit per cycle
// over the sums and 48-bit sums of squares (skipped when the pixel count is
// zero), followed by square, subtract and max steps.
// The result lands in an output register; the next word is accepted while it
// waits. A stalled receiver holds the controller before write back, so no
// word is lost or repeated.
// After reset the store is cleared one entry per cycle, all 65536 entries, with
// in_ch.ready low; configuration writes are taken throughout.
// Depends on pva_pkg, pva_in_if, pva_out_if, pva_ctrl, pva_dp and pva_ram.
module pixel_variance_accumulator (
	input  logic                       clk,
	input  logic                       arst_n,
	pva_in_if.sink                     in_ch,
	pva_out_if.source                  out_ch,
	input  logic                       cfg_we,
	input  logic [pva_pkg::CFG_W-1:0]  cfg_wdata
);
	import pva_pkg::*;

	logic [CFG_W-1:0] width_q;
	pva_cmd_t         cmd;
	pva_sts_t         sts;
	pva_item_t        item;
	pva_result_t      result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	assign item.func         = in_ch.func;
	assign item.row          = in_ch.row;
	assign item.col          = in_ch.col;
	assign item.value        = {in_ch.blue_value, in_ch.green_value, in_ch.red_value};
	assign item.square_sum   = {in_ch.blue_square_sum, in_ch.green_square_sum,
		in_ch.red_square_sum};
	assign item.sample_total = in_ch.sample_total;

	pva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pva_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_width (width_q),
		.item      (item),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.result    (result)
	);

	assign out_ch.max_variance = result.max_variance;
	assign out_ch.samples_now  = result.samples_now;
	assign out_ch.index_error  = result.index_error;

`ifndef SYNTH
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.index_error |->
			out_ch.max_variance == '0 && out_ch.samples_now == '0)
		else $error("index error result carries nonzero payload");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && (cmd.ram_we || cmd.clr_we)))
		else $error("store read issued during a write back");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("second word accepted before the first was executed");
`endif
endmodule

// ----- hdl/pva_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module pva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hdl/pva_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: clearing pass, read-modify-write and query sequence.
// Depends on pva_pkg; drives pva_dp through command and status structs.
module pva_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pva_pkg::pva_sts_t sts,
	output pva_pkg::pva_cmd_t cmd
);
	import pva_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.op_query && !sts.idx_err) begin
					state_nxt = sts.n_zero ? ST_MUL : ST_DIV;
				end else if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (sts.div_last) state_nxt = ST_MUL;
			end
			ST_MUL:  state_nxt = ST_SUB;
			ST_SUB:  state_nxt = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_we = 1'b1;
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				if (sts.op_query && !sts.idx_err) begin
					cmd.div_load = 1'b1;
				end else if (sts.out_free) begin
					// write back and deliver in the same cycle
					cmd.out_exec = 1'b1;
					cmd.ram_we   = sts.op_write && !sts.idx_err;
				end
			end
			ST_DIV:  cmd.div_step = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_SUB:  cmd.sub = 1'b1;
			ST_DONE: cmd.out_query = sts.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

// ----- hdl/pva_dp.sv -----
`timescale 1ns / 1ps
// Datapath: pixel store, item registers, update logic, divider lanes,
// variance arithmetic and the output register. Depends on pva_pkg and pva_ram.
module pva_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pva_pkg::pva_cmd_t        cmd,
	output pva_pkg::pva_sts_t        sts,
	input  logic [pva_pkg::CFG_W-1:0] cfg_width,
	input  pva_pkg::pva_item_t       item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pva_pkg::pva_result_t     result
);
	import pva_pkg::*;

	logic [IDX_W-1:0]  idx_in;
	logic [ADDR_W-1:0] clr_q;
	logic [FUNC_W-1:0] func_q;
	logic [ADDR_W-1:0] addr_q;
	logic              err_q;
	logic [NCH-1:0][SUM_W-1:0] val_q;
	logic [NCH-1:0][SQ_W-1:0]  sqv_q;
	logic [CNT_W-1:0]          total_q;

	store_word_t rd_word, nxt_word, wr_word;
	logic [$bits(store_word_t)-1:0] rdata;
	logic              we;
	logic [ADDR_W-1:0] waddr;

	logic [NCH-1:0][SMP_W-1:0] smp;
	logic [NCH-1:0][SUM_W-1:0] sqr;
	logic [NCH-1:0][SUM_W:0]   sum_ext;
	logic [NCH-1:0][SQ_W:0]    sq_ext;

	logic [NLANE-1:0][SQ_W-1:0]  quo_q;
	logic [NLANE-1:0][CNT_W-1:0] rem_q;
	logic [CNT_W-1:0]            n_q;
	logic [DCNT_W-1:0]           div_cnt_q;
	logic [NLANE-1:0][CNT_W:0]   shifted;

	logic [NCH-1:0][2*SUM_W-1:0] m2_q;
	logic [NCH-1:0][2*SUM_W-1:0] diff;
	logic [NCH-1:0][VAR_W-1:0]   var_q;
	logic [VAR_W-1:0]            var_max;

	logic              out_valid_q;
	pva_result_t       res_q;

	assign idx_in = IDX_W'(item.row) * IDX_W'(cfg_width) + IDX_W'(item.col);

	pva_ram #(
		.WIDTH ($bits(store_word_t)),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_word),
		.re    (cmd.capture),
		.raddr (idx_in[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign rd_word = store_word_t'(rdata);
	assign we      = cmd.ram_we | cmd.clr_we;
	assign waddr   = cmd.clr_we ? clr_q : addr_q;
	assign wr_word = cmd.clr_we ? store_word_t'('0) : nxt_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= item.func;
			addr_q  <= idx_in[ADDR_W-1:0];
			err_q   <= idx_in >= IDX_W'(STORE_DEPTH);
			val_q   <= item.value;
			sqv_q   <= item.square_sum;
			total_q <= item.sample_total;
		end
	end

	// new pixel word for every func; query and unknown codes keep the old one
	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			smp[k] = (func_q == FUNC_ACC_MONO) ? val_q[0][SMP_W-1:0] : val_q[k][SMP_W-1:0];
			sqr[k] = SUM_W'(smp[k]) * SUM_W'(smp[k]);
			sum_ext[k] = {1'b0, rd_word.sum[k]} + (SUM_W+1)'(smp[k]);
			sq_ext[k]  = {1'b0, rd_word.sq[k]} + (SQ_W+1)'(sqr[k]);
		end
		nxt_word = rd_word;
		case (func_q)
			FUNC_ACC_RGB, FUNC_ACC_MONO: begin
				for (int k = 0; k < NCH; k++) begin
					nxt_word.sum[k] = sum_ext[k][SUM_W] ? '1 : sum_ext[k][SUM_W-1:0];
					nxt_word.sq[k]  = sq_ext[k][SQ_W] ? '1 : sq_ext[k][SQ_W-1:0];
				end
				if (rd_word.cnt != '1) nxt_word.cnt = rd_word.cnt + 1'b1;
			end
			FUNC_SET: begin
				nxt_word.sum = val_q;
				nxt_word.sq  = sqv_q;
				nxt_word.cnt = total_q;
			end
			FUNC_CLEAR: nxt_word = '0;
			default:    nxt_word = rd_word;
		endcase
	end

	// restoring division, one quotient bit per lane per cycle
	always_comb begin
		for (int j = 0; j < NLANE; j++) begin
			shifted[j] = {rem_q[j], quo_q[j][SQ_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			n_q <= rd_word.cnt;
			for (int k = 0; k < NCH; k++) begin
				quo_q[k]       <= SQ_W'(rd_word.sum[k]);
				quo_q[k + NCH] <= rd_word.sq[k];
				rem_q[k]       <= '0;
				rem_q[k + NCH] <= '0;
			end
		end else if (cmd.div_step) begin
			for (int j = 0; j < NLANE; j++) begin
				if (shifted[j] >= {1'b0, n_q}) begin
					rem_q[j] <= CNT_W'(shifted[j] - {1'b0, n_q});
					quo_q[j] <= {quo_q[j][SQ_W-2:0], 1'b1};
				end else begin
					rem_q[j] <= shifted[j][CNT_W-1:0];
					quo_q[j] <= {quo_q[j][SQ_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			diff[k] = (2*SUM_W)'(quo_q[k + NCH]) - m2_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int k = 0; k < NCH; k++) begin
				m2_q[k] <= (2*SUM_W)'(quo_q[k][SUM_W-1:0]) * (2*SUM_W)'(quo_q[k][SUM_W-1:0]);
			end
		end
		if (cmd.sub) begin
			for (int k = 0; k < NCH; k++) begin
				if ((2*SUM_W)'(quo_q[k + NCH]) <= m2_q[k]) begin
					var_q[k] <= '0;
				end else begin
					var_q[k] <= (diff[k][2*SUM_W-1:VAR_W] != '0) ? '1 : diff[k][VAR_W-1:0];
				end
			end
		end
	end

	always_comb begin
		var_max = var_q[0];
		if (var_q[1] > var_max) var_max = var_q[1];
		if (var_q[2] > var_max) var_max = var_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_exec || cmd.out_query) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_exec) begin
			res_q.max_variance <= '0;
			res_q.samples_now  <= err_q ? '0 : nxt_word.cnt;
			res_q.index_error  <= err_q;
		end else if (cmd.out_query) begin
			res_q.max_variance <= var_max;
			res_q.samples_now  <= n_q;
			res_q.index_error  <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

	assign sts.idx_err  = err_q;
	assign sts.op_query = func_q == FUNC_QUERY;
	assign sts.op_write = (func_q == FUNC_ACC_RGB) || (func_q == FUNC_ACC_MONO)
		|| (func_q == FUNC_SET) || (func_q == FUNC_CLEAR);
	assign sts.n_zero   = rd_word.cnt == '0;
	assign sts.div_last = div_cnt_q == DCNT_W'(SQ_W - 1);
	assign sts.clr_last = &clr_q;
	assign sts.out_free = !out_valid_q || out_ready;
endmodule
